// ===== hw/rtl/gda_pkg.sv =====
// Package of constants and calendar tables for the Gregorian date arithmetic block.
package gda_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned WEEK_W  = 6;
  localparam int unsigned SER_W   = 22;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned CORR_W  = 12;
  localparam int unsigned Q100_W  = 8;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 128;

  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [YEAR_W-1:0]  MIN_YEAR = 14'd1;
  localparam logic [MONTH_W-1:0] JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] DEC     = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DEC_DAY = 5'd31;

  // Reciprocal of 100 for 14-bit dividends: q = (x * 5243) >> 19.
  localparam logic [12:0] RECIP100       = 13'd5243;
  localparam int unsigned RECIP100_SHIFT = 19;
  localparam logic [6:0]  CENTURY        = 7'd100;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;

  // Reciprocal of 7 for dividends below 366: q = (x * 293) >> 11.
  localparam logic [8:0]  RECIP7       = 9'd293;
  localparam int unsigned RECIP7_SHIFT = 11;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/gregorian_date_arithmetic.sv =====
// Gregorian date check, neighbor dates, ordinal and serial day numbers and day difference.
//
//   channel | direction | tdata                          | tuser
//   in_     | slave     | main date and comparison date  | none
//   out_    | master    | neighbor dates, ordinals, diff | date_valid
//
// Four register stages: divide by 100, leap and neighbor dates, serial sum, difference.
// One word per cycle while no stall on out_tready holds the pipeline.
// Each stage holds its word while the next stage is full and stalled, so a stall
// on out_tready backs up stage by stage to in_tready without losing a word.
// Reset clears only the stage valid bits.
module gregorian_date_arithmetic (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // day[4:0], month[8:5], year[22:9], other_day[27:23], other_month[31:28],
  // other_year[45:32], zero[47:46]
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_day_of_month[4:0], next_month_num[8:5], next_year_num[22:9],
  // prev_day_of_month[27:23], prev_month_num[31:28], prev_year_num[45:32],
  // day_of_year[54:46], week_of_year[60:55], serial_day[82:61],
  // day_difference[105:83], day_distance[127:106]
  output logic [127:0] out_tdata,
  // date_valid[0]
  output logic         out_tuser
);

  localparam int unsigned DW = gda_pkg::DAY_W;
  localparam int unsigned MW = gda_pkg::MONTH_W;
  localparam int unsigned YW = gda_pkg::YEAR_W;
  localparam int unsigned QW = gda_pkg::Q100_W;
  localparam int unsigned OW = gda_pkg::DOY_W;
  localparam int unsigned SW = gda_pkg::SER_W;
  localparam int unsigned CW = gda_pkg::CORR_W;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: clamp the comparison year and month and divide both years by 100.
  logic [DW-1:0] in_d, in_od;
  logic [MW-1:0] in_m, in_om, om_c;
  logic [YW-1:0] in_y, in_oy, oy_c;
  logic [26:0]   qy_prod, qoy_prod;

  assign in_d  = in_tdata[4:0];
  assign in_m  = in_tdata[8:5];
  assign in_y  = in_tdata[22:9];
  assign in_od = in_tdata[27:23];
  assign in_om = in_tdata[31:28];
  assign in_oy = in_tdata[45:32];

  always_comb begin
    priority if (in_oy < gda_pkg::MIN_YEAR) oy_c = gda_pkg::MIN_YEAR;
    else if (in_oy > gda_pkg::MAX_YEAR)      oy_c = gda_pkg::MAX_YEAR;
    else                                     oy_c = in_oy;
    priority if (in_om < gda_pkg::JAN) om_c = gda_pkg::JAN;
    else if (in_om > gda_pkg::DEC)     om_c = gda_pkg::DEC;
    else                               om_c = in_om;
  end

  assign qy_prod  = 27'(in_y) * 27'(gda_pkg::RECIP100);
  assign qoy_prod = 27'(oy_c) * 27'(gda_pkg::RECIP100);

  logic [DW-1:0] d1_r, od1_r;
  logic [MW-1:0] m1_r, om1_r;
  logic [YW-1:0] y1_r, oy1_r;
  logic [QW-1:0] qy1_r, qoy1_r;

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      d1_r   <= in_d;
      m1_r   <= in_m;
      y1_r   <= in_y;
      od1_r  <= in_od;
      om1_r  <= om_c;
      oy1_r  <= oy_c;
      qy1_r  <= qy_prod[gda_pkg::RECIP100_SHIFT +: QW];
      qoy1_r <= qoy_prod[gda_pkg::RECIP100_SHIFT +: QW];
    end
  end

  // Stage 2: leap years, validity, neighbor dates, ordinals and year bases.
  logic [14:0]   ry;
  logic [14:0]   roy;
  logic          leap, oleap, ok;
  logic [QW-1:0] p100, op100;
  logic [YW-1:0] p, op;
  logic [DW-1:0] len, plen;
  logic [DW-1:0] nd, pd;
  logic [MW-1:0] nm, pm;
  logic [YW-1:0] ny, py;
  logic [OW-1:0] doy, odoy;
  logic [SW-1:0] yb, oyb;
  logic [CW-1:0] cr, ocr;
  logic [22:0]   yb_prod, oyb_prod;

  assign ry  = {1'b0, y1_r}  - (15'(qy1_r)  * 15'(gda_pkg::CENTURY));
  assign roy = {1'b0, oy1_r} - (15'(qoy1_r) * 15'(gda_pkg::CENTURY));

  assign leap  = (ry == 15'd0)  ? (qy1_r[1:0] == 2'd0)  : (y1_r[1:0] == 2'd0);
  assign oleap = (roy == 15'd0) ? (qoy1_r[1:0] == 2'd0) : (oy1_r[1:0] == 2'd0);

  assign p     = y1_r - gda_pkg::MIN_YEAR;
  assign op    = oy1_r - gda_pkg::MIN_YEAR;
  assign p100  = qy1_r  - QW'(ry == 15'd0);
  assign op100 = qoy1_r - QW'(roy == 15'd0);

  assign len  = gda_pkg::month_len(m1_r, leap);
  assign plen = gda_pkg::month_len(m1_r - gda_pkg::JAN, leap);

  assign ok = (y1_r >= gda_pkg::MIN_YEAR) && (y1_r <= gda_pkg::MAX_YEAR)
           && (m1_r >= gda_pkg::JAN) && (m1_r <= gda_pkg::DEC)
           && (d1_r >= gda_pkg::FIRST_DAY) && (d1_r <= len);

  always_comb begin
    priority if (d1_r == gda_pkg::LAST_DEC_DAY && m1_r == gda_pkg::DEC
                 && y1_r == gda_pkg::MAX_YEAR) begin
      nd = d1_r;
      nm = m1_r;
      ny = y1_r;
    end else if (d1_r != len) begin
      nd = d1_r + 5'd1;
      nm = m1_r;
      ny = y1_r;
    end else if (m1_r < gda_pkg::DEC) begin
      nd = gda_pkg::FIRST_DAY;
      nm = m1_r + 4'd1;
      ny = y1_r;
    end else begin
      nd = gda_pkg::FIRST_DAY;
      nm = gda_pkg::JAN;
      ny = y1_r + 14'd1;
    end
    priority if (d1_r == gda_pkg::FIRST_DAY && m1_r == gda_pkg::JAN
                 && y1_r == gda_pkg::MIN_YEAR) begin
      pd = d1_r;
      pm = m1_r;
      py = y1_r;
    end else if (d1_r != gda_pkg::FIRST_DAY) begin
      pd = d1_r - 5'd1;
      pm = m1_r;
      py = y1_r;
    end else if (m1_r > gda_pkg::JAN) begin
      pd = plen;
      pm = m1_r - 4'd1;
      py = y1_r;
    end else begin
      pd = gda_pkg::LAST_DEC_DAY;
      pm = gda_pkg::DEC;
      py = y1_r - 14'd1;
    end
  end

  assign doy  = gda_pkg::days_before(m1_r) + OW'(d1_r)
              + OW'(m1_r > gda_pkg::FEB && leap);
  assign odoy = gda_pkg::days_before(om1_r) + OW'(od1_r)
              + OW'(om1_r > gda_pkg::FEB && oleap);

  assign yb_prod  = 23'(p)  * 23'(gda_pkg::DAYS_PER_YEAR);
  assign oyb_prod = 23'(op) * 23'(gda_pkg::DAYS_PER_YEAR);
  assign yb  = yb_prod[SW-1:0];
  assign oyb = oyb_prod[SW-1:0];

  assign cr  = p[YW-1:2]  - CW'(p100)  + CW'(p100[QW-1:2]);
  assign ocr = op[YW-1:2] - CW'(op100) + CW'(op100[QW-1:2]);

  logic          ok2_r;
  logic [DW-1:0] nd2_r, pd2_r;
  logic [MW-1:0] nm2_r, pm2_r;
  logic [YW-1:0] ny2_r, py2_r;
  logic [OW-1:0] doy2_r, odoy2_r;
  logic [SW-1:0] yb2_r, oyb2_r;
  logic [CW-1:0] cr2_r, ocr2_r;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      ok2_r   <= ok;
      nd2_r   <= nd;
      nm2_r   <= nm;
      ny2_r   <= ny;
      pd2_r   <= pd;
      pm2_r   <= pm;
      py2_r   <= py;
      doy2_r  <= doy;
      odoy2_r <= odoy;
      yb2_r   <= yb;
      oyb2_r  <= oyb;
      cr2_r   <= cr;
      ocr2_r  <= ocr;
    end
  end

  // Stage 3: serial day numbers and week of year.
  logic [OW-1:0] doy_m1;
  logic [17:0]   wk_prod;
  logic [6:0]    wk;

  assign doy_m1  = doy2_r - 9'd1;
  assign wk_prod = 18'(doy_m1) * 18'(gda_pkg::RECIP7);
  assign wk      = wk_prod[gda_pkg::RECIP7_SHIFT +: 7] + 7'd1;

  logic          ok3_r;
  logic [DW-1:0] nd3_r, pd3_r;
  logic [MW-1:0] nm3_r, pm3_r;
  logic [YW-1:0] ny3_r, py3_r;
  logic [OW-1:0] doy3_r;
  logic [5:0]    wk3_r;
  logic [SW-1:0] ser3_r, oser3_r;

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      ok3_r   <= ok2_r;
      nd3_r   <= nd2_r;
      nm3_r   <= nm2_r;
      ny3_r   <= ny2_r;
      pd3_r   <= pd2_r;
      pm3_r   <= pm2_r;
      py3_r   <= py2_r;
      doy3_r  <= doy2_r;
      wk3_r   <= wk[5:0];
      ser3_r  <= yb2_r + SW'(cr2_r) + SW'(doy2_r);
      oser3_r <= oyb2_r + SW'(ocr2_r) + SW'(odoy2_r);
    end
  end

  // Stage 4: difference, distance and zeroing of invalid dates.
  logic [22:0]   diff, ndiff;
  logic [SW-1:0] distance;

  assign diff     = {1'b0, oser3_r} - {1'b0, ser3_r};
  assign ndiff    = {1'b0, ser3_r} - {1'b0, oser3_r};
  assign distance = diff[22] ? ndiff[SW-1:0] : diff[SW-1:0];

  logic         ok4_r;
  logic [127:0] data4_r;

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      ok4_r <= ok3_r;
      if (ok3_r) begin
        data4_r <= {distance, diff, ser3_r, wk3_r, doy3_r,
                    py3_r, pm3_r, pd3_r, ny3_r, nm3_r, nd3_r};
      end else begin
        data4_r <= '0;
      end
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = data4_r;
  assign out_tuser  = ok4_r;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 128'd0)
    else $error("invalid date gave a nonzero result");

  a_next_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[8:5] >= gda_pkg::JAN
                             && out_tdata[8:5] <= gda_pkg::DEC)
    else $error("next month out of range on a valid date");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && !out_tready)
    else $error("input blocked while the pipeline has a free stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted word missing from the first stage");
`endif

endmodule
